FILE: sv/dcn_esc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcn_esc_pkg
// constants, codes and character helpers for the dcn escape encoder
// ----------------------------------------------------------------------------
package dcn_esc_pkg;

	localparam int unsigned OUTPUT_CAP  = 2038;
	localparam int unsigned INPUT_LIMIT = 2048;
	localparam int unsigned RUN_LEN     = 10;

	localparam int unsigned EMIT_W = 11;
	localparam int unsigned CONS_W = 12;
	localparam int unsigned IDX_W  = 4;

	localparam logic [1:0] ST_EMIT = 2'd0;
	localparam logic [1:0] ST_CAP  = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_N       = 8'h4e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RUN_LEN - 1);

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       esc;
		logic       last;
	} job_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == 8'd0) || (b == 8'd5) || (b == 8'd36) || (b == 8'd96) ||
			(b == 8'd124) || (b == 8'd126);
	endfunction

	// three decimal digits of an escaped byte, hundreds in the top nibble
	function automatic logic [11:0] esc_digits(input logic [7:0] b);
		logic [11:0] d;
		d = 12'h000;
		case (b)
			8'd5:    d = 12'h005;
			8'd36:   d = 12'h036;
			8'd96:   d = 12'h096;
			8'd124:  d = 12'h124;
			8'd126:  d = 12'h126;
			default: d = 12'h000;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] run_char(input logic [7:0] b, input logic [IDX_W-1:0] idx);
		logic [11:0] d;
		logic [7:0]  ch;
		d  = esc_digits(b);
		ch = CH_SLASH;
		case (idx)
			4'd0:    ch = CH_SLASH;
			4'd1:    ch = CH_PERCENT;
			4'd2:    ch = CH_D;
			4'd3:    ch = CH_C;
			4'd4:    ch = CH_N;
			4'd5:    ch = CH_ZERO | {4'h0, d[11:8]};
			4'd6:    ch = CH_ZERO | {4'h0, d[7:4]};
			4'd7:    ch = CH_ZERO | {4'h0, d[3:0]};
			4'd8:    ch = CH_PERCENT;
			default: ch = CH_SLASH;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: sv/dcn_escape_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcn_escape_encoder
// escapes a byte stream into /%DCNddd%/ runs with output cap and input limit
// ----------------------------------------------------------------------------
// the first result word goes through the job register and then the output register
// throughput: one input word per cycle for plain or dropped bytes while the output is not stalled
// an escaped byte holds the job register for a run of ten chars, one run char a cycle while the output is not stalled
// reset clears both counts and the valid flags of the job and output registers
// ----------------------------------------------------------------------------
module dcn_escape_encoder
	import dcn_esc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tuser,  // [0] first_byte
	input  wire logic       s_axis_tlast,  // last_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic [2:0]      m_axis_tuser,  // [1:0] status, [2] run_last
	output logic            m_axis_tlast   // string_end
);

	logic [EMIT_W-1:0] emit_q;
	logic [CONS_W-1:0] cons_q;

	logic              job_valid_s1;
	job_t              job_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [1:0]        out_status_q;
	logic              out_run_last_q;
	logic              out_end_q;

	logic              in_take;
	logic [EMIT_W-1:0] emit_eff;
	logic [CONS_W-1:0] pos;
	logic              too_long;
	logic              capped;
	logic              do_esc;
	job_t              job_d;
	logic [EMIT_W-1:0] emit_d;
	logic [CONS_W-1:0] cons_d;

	logic              advance;
	logic              job_done;
	logic [7:0]        word_byte;
	logic              word_run_last;

	// decision at accept time
	always_comb begin
		emit_eff = s_axis_tuser ? '0 : emit_q;
		pos      = s_axis_tuser ? '0 : cons_q;
		too_long = pos >= CONS_W'(INPUT_LIMIT);
		capped   = emit_eff >= EMIT_W'(OUTPUT_CAP);
		do_esc   = needs_escape(s_axis_tdata) && !(pos == '0 && s_axis_tdata == CH_DOLLAR);

		job_d.data = s_axis_tdata;
		job_d.last = s_axis_tlast;
		job_d.esc  = 1'b0;
		emit_d     = emit_eff;
		priority if (too_long) begin
			job_d.status = ST_LONG;
		end else if (capped) begin
			job_d.status = ST_CAP;
		end else if (do_esc) begin
			job_d.status = ST_EMIT;
			job_d.esc    = 1'b1;
			emit_d       = emit_eff + EMIT_W'(RUN_LEN);
		end else begin
			job_d.status = ST_EMIT;
			emit_d       = emit_eff + EMIT_W'(1);
		end
		cons_d = too_long ? pos : pos + CONS_W'(1);
		if (s_axis_tlast) begin
			emit_d = '0;
			cons_d = '0;
		end
	end

	// word produced by the job register
	always_comb begin
		if (job_s1.esc) begin
			word_byte     = run_char(job_s1.data, idx_s1);
			word_run_last = idx_s1 == IDX_LAST;
		end else begin
			word_byte     = (job_s1.status == ST_EMIT) ? job_s1.data : 8'h00;
			word_run_last = 1'b1;
		end
	end

	assign advance       = job_valid_s1 && (!out_valid_q || m_axis_tready);
	assign job_done      = advance && word_run_last;
	assign s_axis_tready = !job_valid_s1 || job_done;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q       <= '0;
			cons_q       <= '0;
			job_valid_s1 <= 1'b0;
			idx_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_take) begin
				emit_q       <= emit_d;
				cons_q       <= cons_d;
				job_valid_s1 <= 1'b1;
				idx_s1       <= '0;
			end else if (job_done) begin
				job_valid_s1 <= 1'b0;
			end else if (advance) begin
				idx_s1 <= idx_s1 + IDX_W'(1);
			end
			out_valid_q <= advance || (out_valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			job_s1 <= job_d;
		end
		if (advance) begin
			out_byte_q     <= word_byte;
			out_status_q   <= job_s1.status;
			out_run_last_q <= word_run_last;
			out_end_q      <= word_run_last && job_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = {out_run_last_q, out_status_q};
	assign m_axis_tlast  = out_end_q;

`ifndef SYNTH
	a_end_on_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
		else $error("string end without run end");

	a_drop_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] != ST_EMIT |-> m_axis_tdata == 8'h00 && m_axis_tuser[2])
		else $error("dropped byte result malformed");

	a_cons_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cons_q <= CONS_W'(INPUT_LIMIT))
		else $error("input count past limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> emit_q == '0 && cons_q == '0)
		else $error("counts not cleared after last byte");
`endif

endmodule
`default_nettype wire
